// ===== design/b85e_pkg.sv =====
package b85e_pkg;

    localparam int unsigned BYTES_PER_GROUP  = 4;
    localparam int unsigned DIGITS_PER_GROUP = 5;
    localparam int unsigned PIPE_STAGES      = DIGITS_PER_GROUP - 1;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned QUOT_W  = 26;     // ceil(log2(2^32 / 85))
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned CHAR_W  = 7;

    // Exact reciprocal for unsigned 32-bit division by 85: (x * M) >> 38
    localparam logic [31:0] RECIP85  = 32'hC0C0C0C1;
    localparam int unsigned RECIP_SH = 38;

    localparam logic [DIGIT_W-1:0] DIG_UPPER = 7'd10;
    localparam logic [DIGIT_W-1:0] DIG_LOWER = 7'd36;
    localparam logic [DIGIT_W-1:0] DIG_PUNCT = 7'd62;
    localparam int unsigned PUNCT_N = 23;

    localparam logic [CHAR_W-1:0] PUNCT [PUNCT_N] = '{
        7'h21, 7'h23, 7'h24, 7'h25, 7'h26, 7'h28, 7'h29, 7'h2A,
        7'h2B, 7'h2D, 7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40,
        7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_group;

    typedef struct packed {
        logic [DIGITS_PER_GROUP-1:0][DIGIT_W-1:0] dig;   // index 0 is most significant
        logic                                     last;
    } t_digits;

    function automatic logic [QUOT_W-1:0] div85(input logic [WORD_W-1:0] x);
        logic [63:0] p;
        p = {32'b0, x} * {32'b0, RECIP85};
        return p[RECIP_SH +: QUOT_W];
    endfunction

    // n - 85*q, known to lie in 0..84
    function automatic logic [DIGIT_W-1:0] rem85(input logic [WORD_W-1:0] n,
                                                 input logic [QUOT_W-1:0] q);
        logic [WORD_W-1:0] qx;
        logic [WORD_W-1:0] diff;
        qx   = {{(WORD_W-QUOT_W){1'b0}}, q};
        diff = n - ((qx << 6) + (qx << 4) + (qx << 2) + qx);
        return diff[DIGIT_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
        logic [4:0] idx;
        logic [CHAR_W-1:0] c;
        idx = 5'(d - DIG_PUNCT);
        if (d < DIG_UPPER) begin
            c = d + 7'd48;
        end else if (d < DIG_LOWER) begin
            c = d + 7'd55;
        end else if (d < DIG_PUNCT) begin
            c = d + 7'd61;
        end else if (idx < 5'(PUNCT_N)) begin
            c = PUNCT[idx];
        end else begin
            c = PUNCT[PUNCT_N-1];
        end
        return c;
    endfunction

endpackage

// ===== design/b85e_pack.sv =====
module b85e_pack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_grp_valid,
    input  logic                 i_grp_ready,
    output b85e_pkg::t_group     o_grp
);

    logic [b85e_pkg::WORD_W-1:0] r_word;
    logic [1:0]                  r_cnt;
    logic                        r_gvalid;
    b85e_pkg::t_group            r_grp;

    logic [b85e_pkg::WORD_W-1:0] merged;
    logic                        accept;
    logic                        closing;

    assign o_ready = !r_gvalid || i_grp_ready;
    assign accept  = i_valid && o_ready;
    assign closing = (r_cnt == 2'(b85e_pkg::BYTES_PER_GROUP - 1)) || i_last;
    assign merged  = r_word | ({i_byte, 24'b0} >> {r_cnt, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word   <= '0;
            r_cnt    <= '0;
            r_gvalid <= 1'b0;
        end else begin
            // Hold a pending group until taken, raise on a closing byte
            r_gvalid <= (accept && closing) || (r_gvalid && !i_grp_ready);
            if (accept) begin
                if (closing) begin
                    r_word   <= '0;
                    r_cnt    <= '0;
                end else begin
                    r_word <= merged;
                    r_cnt  <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && closing) begin
            r_grp.word <= merged;
            r_grp.last <= i_last;
        end
    end

    assign o_grp_valid = r_gvalid;
    assign o_grp       = r_grp;

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && closing |=> r_cnt == 2'd0 && r_word == '0 && r_gvalid)
        else $error("closing word did not reset the group");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gvalid && !i_grp_ready |=> r_gvalid && $stable(r_grp))
        else $error("pending group lost while stalled");

endmodule

// ===== design/b85e_digits.sv =====
module b85e_digits (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  b85e_pkg::t_group     i_grp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b85e_pkg::t_digits    o_dig
);

    localparam int unsigned NS = b85e_pkg::PIPE_STAGES;

    logic [b85e_pkg::WORD_W-1:0]                             r_n    [NS];
    logic [b85e_pkg::QUOT_W-1:0]                             r_q    [NS];
    logic [b85e_pkg::DIGITS_PER_GROUP-1:0][b85e_pkg::DIGIT_W-1:0] r_d [NS];
    logic [b85e_pkg::DIGITS_PER_GROUP-1:0][b85e_pkg::DIGIT_W-1:0] n_d [NS];
    logic                                                    r_last [NS];
    logic [NS-1:0]                                           r_v;
    logic [NS:0]                                             rdy;

    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0 divides the word by 85; each later stage divides the previous quotient by 85 and peels off one digit
    always_comb begin
        n_d[0] = '0;
        for (int k = 1; k < NS; k++) begin
            n_d[k] = r_d[k-1];
            n_d[k][b85e_pkg::DIGITS_PER_GROUP-k] = b85e_pkg::rem85(r_n[k-1], r_q[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_n[0]    <= i_grp.word;
            r_q[0]    <= b85e_pkg::div85(i_grp.word);
            r_d[0]    <= n_d[0];
            r_last[0] <= i_grp.last;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k] && r_v[k-1]) begin
                r_n[k]    <= {{(b85e_pkg::WORD_W-b85e_pkg::QUOT_W){1'b0}}, r_q[k-1]};
                r_q[k]    <= b85e_pkg::div85(
                                 {{(b85e_pkg::WORD_W-b85e_pkg::QUOT_W){1'b0}}, r_q[k-1]});
                r_d[k]    <= n_d[k];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    always_comb begin
        o_dig.dig    = r_d[NS-1];
        o_dig.dig[1] = b85e_pkg::rem85(r_n[NS-1], r_q[NS-1]);
        o_dig.dig[0] = r_q[NS-1][b85e_pkg::DIGIT_W-1:0];
        o_dig.last   = r_last[NS-1];
    end

    assign o_valid = r_v[NS-1];

endmodule

// ===== design/b85e_serial.sv =====
module b85e_serial (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  b85e_pkg::t_digits            i_dig,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b85e_pkg::CHAR_W-1:0]  o_char,
    output logic                         o_group_end,
    output logic                         o_stream_end
);

    localparam logic [2:0] LAST_POS = 3'(b85e_pkg::DIGITS_PER_GROUP - 1);

    logic [b85e_pkg::CHAR_W-1:0] r_chr [b85e_pkg::DIGITS_PER_GROUP];
    logic [2:0]                  r_pos;
    logic                        r_valid;
    logic                        r_last;

    logic take;
    logic load;

    assign take    = r_valid && i_ready;
    assign o_ready = !r_valid || (take && r_pos == LAST_POS);
    assign load    = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= '0;
        end else if (take) begin
            if (r_pos == LAST_POS) begin
                r_valid <= 1'b0;
                r_pos   <= '0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    // Map all five digits at load, shift the head out on each word taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < b85e_pkg::DIGITS_PER_GROUP; k++) begin
                r_chr[k] <= b85e_pkg::to_char(i_dig.dig[k]);
            end
            r_last <= i_dig.last;
        end else if (take) begin
            for (int k = 0; k < b85e_pkg::DIGITS_PER_GROUP - 1; k++) begin
                r_chr[k] <= r_chr[k+1];
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_char       = r_chr[0];
    assign o_group_end  = r_pos == LAST_POS;
    assign o_stream_end = (r_pos == LAST_POS) && r_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("character position out of range");

    a_empty_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> r_pos == 3'd0)
        else $error("position not rewound while empty");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_pos != LAST_POS |=> r_valid && r_pos == $past(r_pos) + 3'd1)
        else $error("character position failed to advance");

endmodule

// ===== design/base85_encoder.sv =====
// Base-85 encoder, RFC 1924 character set.
//
// Slave channel: one raw byte per word on s_axis_tdata[7:0]; s_axis_tlast marks
// the final byte of the data. Bytes pack big-endian into a 32-bit group; a group
// closes on its fourth byte or on a byte with tlast, unfilled low bytes as zero.
// Master channel: five words per group, the base-85 digits most significant
// first, each as an ASCII code on m_axis_tdata[6:0]. m_axis_tuser flags the
// fifth word of every group, m_axis_tlast the fifth word of a group closed by
// tlast. A short final group still gives all five characters.
//
// Path: a group's closing byte is registered in the pack register, then passes
// four divide-by-85 stages and the output shifter before its first character
// is presented. Throughput: one character per cycle on the master side while
// m_axis_tready is high, set by the output shifter; each divide stage registers
// the result of its 32x32 reciprocal multiply. A full group gives 5 characters
// for 4 bytes, and a group closed by tlast after a single byte gives 5 for it.
// Reset clears the open group and all valid flags. When the receiver stalls,
// hold the current character, fill the pipeline, then drop s_axis_tready.
module base85_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,    // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [6:0] out_char, [7] zero
    output logic       m_axis_tuser,    // group_end
    output logic       m_axis_tlast     // stream_end
);

    logic                        grp_valid;
    logic                        grp_ready;
    b85e_pkg::t_group            grp;
    logic                        dig_valid;
    logic                        dig_ready;
    b85e_pkg::t_digits           dig;
    logic [b85e_pkg::CHAR_W-1:0] out_char;

    // Gather bytes into the group word
    b85e_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp       (grp)
    );

    // Split the word into five base-85 digits
    b85e_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (grp_valid),
        .o_ready (grp_ready),
        .i_grp   (grp),
        .o_valid (dig_valid),
        .i_ready (dig_ready),
        .o_dig   (dig)
    );

    // Map to characters and send one per word
    b85e_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dig_valid),
        .o_ready      (dig_ready),
        .i_dig        (dig),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_char       (out_char),
        .o_group_end  (m_axis_tuser),
        .o_stream_end (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule
